>>> rtl/core/backing_store_range_map_assert.svh
// Assertion macros for the backing-store range map.
// Used inside modules that have clk_i and rst_ni; no other dependencies.
`ifndef BACKING_STORE_RANGE_MAP_ASSERT_SVH
`define BACKING_STORE_RANGE_MAP_ASSERT_SVH

// Implication checked in the same cycle
`define BSRM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle
`define BSRM_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bsrm_pkg.sv
// Package for the backing-store range map: payload structs, codes, state enum.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bsrm_pkg;

  // Field widths of the transfer payloads
  localparam int ACTION_W   = 2;
  localparam int PID_W      = 5;
  localparam int VPNO_W     = 20;
  localparam int STORE_W    = 3;
  localparam int NPAGES_W   = 9;
  localparam int OFFSET_W   = 8;
  localparam int INUSE_W    = 16;

  // Parameter defaults
  localparam int DEF_NUM_STORES = 8;
  localparam int DEF_NUM_PROCS  = 32;
  localparam int DEF_PAGE_BITS  = 20;

  // Saturation limits
  localparam logic [7:0]         MAP_COUNT_MAX = 8'hFF;
  localparam logic [INUSE_W-1:0] ALLOC_MAX     = {INUSE_W{1'b1}};

  // Result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC  = 2'd0,
    ACT_FREE   = 2'd1,
    ACT_MAP    = 2'd2,
    ACT_LOOKUP = 2'd3
  } bsrm_action_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_EXEC,
    S_LOOKUP,
    S_FINISH
  } bsrm_state_e;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [PID_W-1:0]    pid;
    logic [VPNO_W-1:0]   vpno;
    logic [STORE_W-1:0]  store;
    logic [NPAGES_W-1:0] npages;
  } bsrm_in_t;

  typedef struct packed {
    logic                status;
    logic [STORE_W-1:0]  store_index;
    logic [OFFSET_W-1:0] page_offset;
    logic [INUSE_W-1:0]  in_use_count;
  } bsrm_out_t;

endpackage

`default_nettype wire

>>> rtl/core/bsrm_seg_mem.sv
// Segment memory: base page and page count per (process, store) entry.
// One write port, one read port with registered data; uses bsrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsrm_seg_mem
  import bsrm_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_STORES * DEF_NUM_PROCS,
  parameter int AW    = 8,
  parameter int W     = DEF_PAGE_BITS + NPAGES_W
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bsrm_range_unit.sv
// Shared range unit: one subtract and compare tests a page against a segment.
// Gives the hit flag and the page offset; uses bsrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsrm_range_unit
  import bsrm_pkg::*;
#(
  parameter int VW = DEF_PAGE_BITS
) (
  input  wire logic [VW-1:0]       vpno_i,
  input  wire logic [VW-1:0]       base_i,
  input  wire logic [NPAGES_W-1:0] count_i,
  output logic                     hit_o,
  output logic [OFFSET_W-1:0]      offset_o
);

  localparam int CMPW = (VW > NPAGES_W) ? VW : NPAGES_W;

  logic [VW:0] diff;

  // Page minus base; no borrow and below the count means inside the range
  always_comb begin
    diff     = {1'b0, vpno_i} - {1'b0, base_i};
    hit_o    = !diff[VW] && (CMPW'(diff[VW-1:0]) < CMPW'(count_i));
    offset_o = diff[OFFSET_W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/core/backing_store_range_map.sv
// Backing-store range map: a global store table and a per-process segment table.
// Top level; uses bsrm_pkg, bsrm_seg_mem, bsrm_range_unit and the assert header.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one request
//   (allocate, free, map, lookup). Output channel out_valid_o / out_stall_i /
//   out_data_o carries exactly one result per request, in request order.
//   A transfer happens on a rising edge with valid high and stall low.
// Steps from input transfer to result register:
//   Free and map take the execute step, then the finish step. Allocate scans
//   one store a cycle up to the first unmapped store (all of them if every
//   store is mapped), then finishes. Lookup reads one entry a cycle and tests
//   it in the range unit the cycle after, up to the first hit or the last store.
// Throughput: one request at a time; in_stall_o is high until its result is
//   registered, so the next transfer can follow in the cycle after at the earliest.
// Reset: all stores unmapped, counts zero, all process entries invalid.
// Stall:
//   A result waits in the output register while out_stall_i is high; the
//   next request is still accepted and its result waits until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

`include "backing_store_range_map_assert.svh"

module backing_store_range_map
  import bsrm_pkg::*;
#(
  parameter int NUM_STORES = DEF_NUM_STORES,
  parameter int NUM_PROCS  = DEF_NUM_PROCS,
  parameter int PAGE_BITS  = DEF_PAGE_BITS
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire bsrm_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output bsrm_out_t      out_data_o
);

  localparam int VW    = (PAGE_BITS < VPNO_W) ? PAGE_BITS : VPNO_W;
  localparam int DEPTH = NUM_STORES * NUM_PROCS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = (NUM_STORES > 1) ? $clog2(NUM_STORES) : 1;
  localparam int CW    = $clog2(NUM_STORES + 1);
  localparam int MW    = VW + NPAGES_W;
  localparam int EXTW  = PID_W + SW + 1;
  localparam int PCW   = PID_W + 2;
  localparam int SCW   = STORE_W + 2;

  localparam logic [PCW-1:0] NP_L    = PCW'(NUM_PROCS);
  localparam logic [SCW-1:0] NS_L    = SCW'(NUM_STORES);
  localparam logic [CW-1:0]  NS_CNT  = CW'(NUM_STORES);
  localparam logic [SW-1:0]  NS_LAST = SW'(NUM_STORES - 1);
  localparam logic [CW-1:0]  NS_LASTC = CW'(NUM_STORES - 1);

  bsrm_state_e state_q, state_d;
  bsrm_in_t    req_q, req_d;
  bsrm_out_t   res_q, res_d;
  bsrm_out_t   out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [INUSE_W-1:0]    alloc_total_q, alloc_total_d;
  logic [NUM_STORES-1:0] smap_q, smap_d;
  logic [7:0]            mcnt_q [NUM_STORES];
  logic [7:0]            mcnt_d [NUM_STORES];
  logic [DEPTH-1:0]      pmap_q, pmap_d;

  logic [CW-1:0] scan_q, scan_d;
  logic [AW-1:0] row_q, row_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [SW-1:0] cmp_idx_q, cmp_idx_d;
  logic          map_bit_q;

  logic          pid_ok, store_ok;
  logic [SW-1:0] sidx;
  logic [AW-1:0] entry;
  logic [AW-1:0] rd_addr;
  logic [7:0]    cnt_new;
  logic          mem_we;
  logic [MW-1:0] mem_wdata;
  logic [MW-1:0] mem_rdata;
  logic          hit;
  logic [OFFSET_W-1:0] offset;
  bsrm_out_t     res_err;

  // Request decode
  always_comb begin
    pid_ok    = {2'b00, req_q.pid} < NP_L;
    store_ok  = {2'b00, req_q.store} < NS_L;
    sidx      = SW'(req_q.store);
    entry     = AW'(EXTW'(req_q.pid) * EXTW'(NUM_STORES) + EXTW'(sidx));
    rd_addr   = row_q + AW'(scan_q);
    mem_wdata = {VW'(req_q.vpno), req_q.npages};
    res_err   = '{status: STATUS_ERR, store_index: '0, page_offset: '0, in_use_count: '0};
  end

  bsrm_seg_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (MW)
  ) u_seg_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (entry),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  bsrm_range_unit #(
    .VW (VW)
  ) u_range (
    .vpno_i   (VW'(req_q.vpno)),
    .base_i   (mem_rdata[MW-1:NPAGES_W]),
    .count_i  (mem_rdata[NPAGES_W-1:0]),
    .hit_o    (hit),
    .offset_o (offset)
  );

  // Valid bit of the entry read alongside the segment memory
  always_ff @(posedge clk_i) begin
    map_bit_q <= pmap_q[rd_addr];
  end

  // Sequencer: next state and table updates
  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    res_d         = res_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    alloc_total_d = alloc_total_q;
    smap_d        = smap_q;
    mcnt_d        = mcnt_q;
    pmap_d        = pmap_q;
    scan_d        = scan_q;
    row_d         = row_q;
    cmp_vld_d     = cmp_vld_q;
    cmp_idx_d     = cmp_idx_q;
    mem_we        = 1'b0;
    cnt_new       = mcnt_q[sidx];
    in_stall_o    = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_data_i;
          scan_d    = '0;
          cmp_vld_d = 1'b0;
          row_d     = AW'(EXTW'(in_data_i.pid) * EXTW'(NUM_STORES));
          case (bsrm_action_e'(in_data_i.action))
            ACT_ALLOC:  state_d = S_ALLOC;
            ACT_LOOKUP: state_d = S_LOOKUP;
            default:    state_d = S_EXEC;
          endcase
        end
      end

      // One store table entry a cycle
      S_ALLOC: begin
        if (!smap_q[scan_q[SW-1:0]]) begin
          res_d = '{status: STATUS_OK, store_index: STORE_W'(scan_q),
                    page_offset: '0, in_use_count: '0};
          if (alloc_total_q != ALLOC_MAX) begin
            alloc_total_d = alloc_total_q + 1'b1;
          end
          state_d = S_FINISH;
        end else if (scan_q == NS_LASTC) begin
          res_d   = res_err;
          state_d = S_FINISH;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end

      // Free or map of one (process, store) entry
      S_EXEC: begin
        state_d = S_FINISH;
        if (!pid_ok || !store_ok) begin
          res_d = res_err;
        end else begin
          res_d = '{status: STATUS_OK, store_index: req_q.store,
                    page_offset: '0, in_use_count: '0};
          if (bsrm_action_e'(req_q.action) == ACT_FREE) begin
            smap_d[sidx] = 1'b0;
            mcnt_d[sidx] = '0;
            pmap_d[entry] = 1'b0;
          end else begin
            if (mcnt_q[sidx] != MAP_COUNT_MAX) begin
              cnt_new = mcnt_q[sidx] + 1'b1;
            end
            mcnt_d[sidx] = cnt_new;
            if (cnt_new == 8'd1) begin
              smap_d[sidx] = 1'b1;
            end
            pmap_d[entry] = 1'b1;
            mem_we        = 1'b1;
          end
        end
      end

      // Read one entry a cycle, test the previous one in the range unit
      S_LOOKUP: begin
        if (!pid_ok) begin
          res_d   = res_err;
          state_d = S_FINISH;
        end else if (cmp_vld_q && map_bit_q && hit) begin
          res_d = '{status: STATUS_OK, store_index: STORE_W'(cmp_idx_q),
                    page_offset: offset, in_use_count: '0};
          state_d = S_FINISH;
        end else if (cmp_vld_q && (cmp_idx_q == NS_LAST)) begin
          res_d   = res_err;
          state_d = S_FINISH;
        end else if (scan_q < NS_CNT) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[SW-1:0];
          scan_d    = scan_q + 1'b1;
        end else begin
          cmp_vld_d = 1'b0;
        end
      end

      // Hand the result to the output register once it is free
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d              = res_q;
          out_d.in_use_count = alloc_total_q;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control and table state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      alloc_total_q <= '0;
      smap_q        <= '0;
      pmap_q        <= '0;
      scan_q        <= '0;
      cmp_vld_q     <= 1'b0;
      for (int i = 0; i < NUM_STORES; i++) begin
        mcnt_q[i] <= '0;
      end
    end else begin
      state_q       <= state_d;
      out_valid_q   <= out_valid_d;
      alloc_total_q <= alloc_total_d;
      smap_q        <= smap_d;
      pmap_q        <= pmap_d;
      scan_q        <= scan_d;
      cmp_vld_q     <= cmp_vld_d;
      mcnt_q        <= mcnt_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    out_q     <= out_d;
    row_q     <= row_d;
    cmp_idx_q <= cmp_idx_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  `BSRM_ASSERT_NXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE,
                   "accepted request left the sequencer idle")
  `BSRM_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(state_q == S_FINISH),
                   "result raised outside the finish step")
  `BSRM_ASSERT_IMP(a_cmp_in_range, state_q == S_LOOKUP && cmp_vld_q,
                   {1'b0, cmp_idx_q} < {1'b0, SW'(NUM_STORES - 1)} + 1'b1,
                   "lookup compare index beyond the store count")
  `BSRM_ASSERT_NXT(a_total_mono, 1'b1, alloc_total_q >= $past(alloc_total_q),
                   "allocation count decreased")

endmodule

`default_nettype wire

>>> tb/sv/bsrm_checker.sv
// Scoreboard for the backing-store range map: watches both channels, predicts
// each result from its own copy of the store and segment tables, compares.
// Depends on bsrm_pkg for the payload structs, action codes and limits.
`timescale 1ns / 1ps

module bsrm_checker
  import bsrm_pkg::*;
#(
  parameter int NUM_STORES = DEF_NUM_STORES,
  parameter int NUM_PROCS  = DEF_NUM_PROCS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  bsrm_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  bsrm_out_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  // Keeps the log readable if the block is badly broken
  localparam int MAX_REPORTS = 100;

  // Shadow tables
  logic                store_busy_q [NUM_STORES];
  logic [7:0]          map_refs_q   [NUM_STORES];
  logic                seg_live_q   [NUM_PROCS][NUM_STORES];
  logic [VPNO_W-1:0]   seg_base_q   [NUM_PROCS][NUM_STORES];
  logic [NPAGES_W-1:0] seg_len_q    [NUM_PROCS][NUM_STORES];
  logic [INUSE_W-1:0]  alloc_count_q;

  // Results still owed by the block, oldest first
  bsrm_out_t owed_results_q[$];

  // Apply one request to the shadow tables and return the result it gives
  function automatic bsrm_out_t apply_request(bsrm_in_t req);
    bsrm_out_t         res;
    logic              hit;
    logic [20:0]       limit;
    logic [VPNO_W-1:0] diff;
    int                p;
    int                s;
    logic              ids_ok;

    res    = '0;
    hit    = 1'b0;
    p      = int'(req.pid);
    s      = int'(req.store);
    ids_ok = (p < NUM_PROCS) && (s < NUM_STORES);

    case (req.action)
      ACT_ALLOC: begin
        // first store not globally mapped; the store is not marked
        for (int i = 0; i < NUM_STORES; i++) begin
          if (!hit && !store_busy_q[i]) begin
            hit             = 1'b1;
            res.store_index = STORE_W'(i);
          end
        end
        if (hit) begin
          if (alloc_count_q != ALLOC_MAX) alloc_count_q++;
          res.status = STATUS_OK;
        end else begin
          res.status = STATUS_ERR;
        end
      end
      ACT_FREE: begin
        if (!ids_ok) begin
          res.status = STATUS_ERR;
        end else begin
          store_busy_q[s] = 1'b0;
          map_refs_q[s]   = '0;
          seg_live_q[p][s] = 1'b0;
          res.status      = STATUS_OK;
          res.store_index = req.store;
        end
      end
      ACT_MAP: begin
        if (!ids_ok) begin
          res.status = STATUS_ERR;
        end else begin
          // saturating reference count; mark only on the first reference
          if (map_refs_q[s] != MAP_COUNT_MAX) map_refs_q[s]++;
          if (map_refs_q[s] == 8'd1) store_busy_q[s] = 1'b1;
          seg_live_q[p][s] = 1'b1;
          seg_base_q[p][s] = req.vpno;
          seg_len_q[p][s]  = req.npages;
          res.status       = STATUS_OK;
          res.store_index  = req.store;
        end
      end
      default: begin
        // lookup: first live segment of the process holding the page
        if (p < NUM_PROCS) begin
          for (int i = 0; i < NUM_STORES; i++) begin
            limit = {1'b0, seg_base_q[p][i]} + 21'(seg_len_q[p][i]);
            if (!hit && seg_live_q[p][i] && req.vpno >= seg_base_q[p][i] &&
                {1'b0, req.vpno} < limit) begin
              hit             = 1'b1;
              diff            = req.vpno - seg_base_q[p][i];
              res.store_index = STORE_W'(i);
              res.page_offset = diff[OFFSET_W-1:0];
            end
          end
        end
        res.status = hit ? STATUS_OK : STATUS_ERR;
      end
    endcase

    res.in_use_count = alloc_count_q;
    return res;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      if (fail_count_o < MAX_REPORTS)
        $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Track transfers on both channels
  always @(posedge clk_i or negedge rst_ni) begin
    bsrm_out_t want;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STORES; s++) begin
        store_busy_q[s] = 1'b0;
        map_refs_q[s]   = '0;
        for (int p = 0; p < NUM_PROCS; p++) begin
          seg_live_q[p][s] = 1'b0;
          seg_base_q[p][s] = '0;
          seg_len_q[p][s]  = '0;
        end
      end
      alloc_count_q = '0;
      owed_results_q.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (in_valid_i && !in_stall_i) owed_results_q.push_back(apply_request(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (owed_results_q.size() == 0) begin
          if (fail_count_o < MAX_REPORTS) $error("result transfer with none outstanding");
          fail_count_o++;
        end else begin
          want = owed_results_q.pop_front();
          compare_field("status", want.status, out_data_i.status);
          compare_field("store_index", want.store_index, out_data_i.store_index);
          compare_field("page_offset", want.page_offset, out_data_i.page_offset);
          compare_field("in_use_count", want.in_use_count, out_data_i.in_use_count);
        end
      end
      pending_o = owed_results_q.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the range map testbench: clock, reset, request traffic, result stalls.
// Instantiates backing_store_range_map and bsrm_checker; uses bsrm_pkg.
`timescale 1ns / 1ps

module testbench;
  import bsrm_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int FLOOD_ALLOCS = 40;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  bsrm_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  bsrm_out_t out_data;
  int        fail_count;
  int        pending;

  // Traffic shaping
  bit quiet      = 1'b0;
  bit no_gaps    = 1'b0;
  int sent_count = 0;
  int stall_left = 0;
  int calm_left  = 0;

  // What the stimulus has mapped, used only to aim lookups
  bit                  seg_known    [32][8];
  logic [VPNO_W-1:0]   seg_base_tb  [32][8];
  logic [NPAGES_W-1:0] seg_len_tb   [32][8];

  backing_store_range_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  bsrm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result-side stall: random bursts separated by calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left = $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      calm_left = $urandom_range(0, 30);
      out_stall <= 1'b0;
    end
  end

  function automatic bsrm_in_t make_req(bsrm_action_e act, int pid, int vpno,
                                        int store, int npages);
    bsrm_in_t r;
    r.action = act;
    r.pid    = PID_W'(pid);
    r.vpno   = VPNO_W'(vpno);
    r.store  = STORE_W'(store);
    r.npages = NPAGES_W'(npages);
    return r;
  endfunction

  // Present one request and hold it until the transfer
  task automatic issue(input bsrm_in_t req);
    if (!quiet && !no_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (in_stall);
    sent_count++;
    case (req.action)
      ACT_MAP: begin
        seg_known[req.pid][req.store]   = 1'b1;
        seg_base_tb[req.pid][req.store] = req.vpno;
        seg_len_tb[req.pid][req.store]  = req.npages;
      end
      ACT_FREE: seg_known[req.pid][req.store] = 1'b0;
      default: ;
    endcase
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  function automatic int pick_pid();
    return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31);
  endfunction

  function automatic int pick_base();
    return $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 20'hFFFFF);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 32);
    if (r < 9) return $urandom_range(0, 511);
    return $urandom_range(257, 511);
  endfunction

  // A page inside the segment, or just outside either end of it
  function automatic int aim_page(int base, int len);
    int r;
    r = $urandom_range(0, 19);
    if (r < 14 && len > 0) return base + $urandom_range(0, len - 1);
    if (r < 17) return base + len;
    return base - 1;
  endfunction

  task automatic random_noise();
    issue(make_req(bsrm_action_e'($urandom_range(0, 3)), $urandom_range(0, 31),
                   $urandom_range(0, 20'hFFFFF), $urandom_range(0, 7),
                   $urandom_range(0, 511)));
  endtask

  // Allocate, map, a few lookups around the range, sometimes a free
  task automatic map_and_probe();
    int p;
    int s;
    int b;
    int l;
    p = pick_pid();
    s = $urandom_range(0, 7);
    b = pick_base();
    l = pick_len();
    issue(make_req(ACT_ALLOC, $urandom, $urandom, $urandom, $urandom));
    issue(make_req(ACT_MAP, p, b, s, l));
    repeat ($urandom_range(1, 4))
      issue(make_req(ACT_LOOKUP, p, aim_page(b, l), $urandom, $urandom));
    if ($urandom_range(0, 9) < 3)
      issue(make_req(ACT_FREE, $urandom_range(0, 3) ? p : pick_pid(), s,
                     $urandom, $urandom));
  endtask

  // Lookup aimed at whatever this process is believed to have mapped
  task automatic probe_existing();
    int p;
    int s;
    int v;
    p = pick_pid();
    s = $urandom_range(0, 7);
    if (seg_known[p][s])
      v = aim_page(seg_base_tb[p][s], seg_len_tb[p][s]);
    else
      v = $urandom_range(0, 20'hFFFFF);
    issue(make_req(ACT_LOOKUP, p, v, $urandom, $urandom));
  endtask

  initial begin
    int start_count;
    int r;
    bit hammered;

    hammered = 1'b0;
    for (int p = 0; p < 32; p++)
      for (int s = 0; s < 8; s++) seg_known[p][s] = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bounds, extremes of the page space, wide offsets,
    // empty and overwritten segments, a full table and frees
    issue(make_req(ACT_ALLOC, 0, 0, 0, 0));
    issue(make_req(ACT_LOOKUP, 0, 0, 0, 0));
    issue(make_req(ACT_MAP, 0, 'h10, 0, 16));
    issue(make_req(ACT_LOOKUP, 0, 'h1F, 0, 0));
    issue(make_req(ACT_LOOKUP, 0, 'h20, 0, 0));
    issue(make_req(ACT_ALLOC, 31, 'hFFFFF, 7, 511));
    issue(make_req(ACT_MAP, 31, 'hFFFFF, 7, 511));
    issue(make_req(ACT_LOOKUP, 31, 'hFFFFF, 7, 511));
    issue(make_req(ACT_MAP, 31, 0, 2, 300));
    issue(make_req(ACT_LOOKUP, 31, 280, 0, 0));
    issue(make_req(ACT_MAP, 31, 0, 1, 0));
    issue(make_req(ACT_LOOKUP, 31, 0, 0, 0));
    issue(make_req(ACT_MAP, 5, 'h18, 0, 4));
    issue(make_req(ACT_MAP, 0, 'h40, 0, 8));
    issue(make_req(ACT_LOOKUP, 0, 'h12, 0, 0));
    issue(make_req(ACT_LOOKUP, 0, 'h47, 0, 0));
    for (int s = 3; s < 7; s++)
      issue(make_req(ACT_MAP, 9, 'h80000 + s * 'h1000, s, 256));
    issue(make_req(ACT_ALLOC, 0, 0, 0, 0));
    issue(make_req(ACT_FREE, 9, 0, 4, 0));
    issue(make_req(ACT_ALLOC, 0, 0, 0, 0));
    issue(make_req(ACT_FREE, 0, 0, 0, 0));
    issue(make_req(ACT_LOOKUP, 5, 'h19, 0, 0));
    drain();

    // Random traffic, mostly well-formed map/lookup sequences
    start_count = sent_count;
    while (sent_count - start_count < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 6) map_and_probe();
      else if (r < 8) probe_existing();
      else random_noise();

      // Once, midway: push one store's map count past saturation
      if (!hammered && sent_count - start_count > RANDOM_ITEMS / 2) begin
        hammered = 1'b1;
        drain();
        repeat (260)
          issue(make_req(ACT_MAP, pick_pid(), pick_base(), 6, pick_len()));
        issue(make_req(ACT_LOOKUP, pick_pid(), pick_base(), 0, 0));
        issue(make_req(ACT_FREE, pick_pid(), 0, 6, 0));
        issue(make_req(ACT_ALLOC, 0, 0, 0, 0));
      end
    end

    // Closing stretch at full rate: a run of allocations, then mixed requests
    quiet   = 1'b1;
    no_gaps = 1'b1;
    issue(make_req(ACT_FREE, 0, 0, 0, 0));
    repeat (FLOOD_ALLOCS)
      issue(make_req(ACT_ALLOC, $urandom, $urandom, $urandom, $urandom));
    repeat (20) random_noise();

    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (20) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
